@@ rtl/stp_pkg.sv @@
// Shared types, op codes and constants for the trapezoid ramp period generator.
package stp_pkg;

   typedef struct packed {
      logic        opcode;
      logic [23:0] total_steps;
   } req_type;

   typedef struct packed {
      logic [31:0] counter_value;
      logic [1:0]  phase;
      logic [31:0] accel_steps_out;
      logic [23:0] decel_steps_out;
      logic [23:0] steps_done;
   } rsp_type;

   typedef struct packed {
      logic [4:0] op;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic sqrt_busy;
      logic limit_gt;
      logic upd_need;
   } status_type;

   // request opcodes
   localparam logic OPC_START = 1'b0;
   localparam logic OPC_NEXT  = 1'b1;

   // phases
   localparam logic [1:0] PH_ACCEL = 2'd0;
   localparam logic [1:0] PH_CONST = 2'd1;
   localparam logic [1:0] PH_DECEL = 2'd2;
   localparam logic [1:0] PH_STOP  = 2'd3;

   // register indexes
   localparam logic [2:0] REG_STEP_ANGLE = 3'd0;
   localparam logic [2:0] REG_TIMER_CLK  = 3'd1;
   localparam logic [2:0] REG_ACCEL      = 3'd2;
   localparam logic [2:0] REG_DECEL      = 3'd3;
   localparam logic [2:0] REG_CRUISE     = 3'd4;

   // datapath ops
   localparam logic [4:0] OP_NONE   = 5'd0;
   localparam logic [4:0] OP_LOAD   = 5'd1;
   localparam logic [4:0] OP_MDEN   = 5'd2;
   localparam logic [4:0] OP_MCS    = 5'd3;
   localparam logic [4:0] OP_DIV    = 5'd4;
   localparam logic [4:0] OP_SSTEPS = 5'd5;
   localparam logic [4:0] OP_SLIM   = 5'd6;
   localparam logic [4:0] OP_SMAG   = 5'd7;
   localparam logic [4:0] OP_SDST   = 5'd8;
   localparam logic [4:0] OP_MT1    = 5'd9;
   localparam logic [4:0] OP_ST1    = 5'd10;
   localparam logic [4:0] OP_MA     = 5'd11;
   localparam logic [4:0] OP_SQ     = 5'd12;
   localparam logic [4:0] OP_MRL    = 5'd13;
   localparam logic [4:0] OP_MRH    = 5'd14;
   localparam logic [4:0] OP_MSUM   = 5'd15;
   localparam logic [4:0] OP_SPR    = 5'd16;
   localparam logic [4:0] OP_NEXT   = 5'd17;
   localparam logic [4:0] OP_DUPD   = 5'd18;
   localparam logic [4:0] OP_SUPD   = 5'd19;

   // arithmetic constants
   localparam logic [31:0] K_DEN_SCALE = 32'd200;     // 2 * 100
   localparam logic [31:0] K_T1_MUL    = 32'd676;
   localparam logic [63:0] K_T1_DIV    = 64'd100000;
   localparam logic [31:0] K_A_LO      = 32'd20000;   // 20000 * 1000000 = 2e10
   localparam logic [31:0] K_A_HI      = 32'd1000000;
   localparam logic [63:0] K_PR_DIV    = 64'd25600;

   // register reset values
   localparam logic [16:0] RST_STEP_ANGLE = 17'd3142;
   localparam logic [29:0] RST_TIMER_CLK  = 30'd1000000;
   localparam logic [23:0] RST_ACCEL      = 24'd10000;
   localparam logic [23:0] RST_DECEL      = 24'd10000;
   localparam logic [23:0] RST_CRUISE     = 24'd1000;

   function automatic logic [31:0] sat32(input logic [63:0] v);
      sat32 = (|v[63:32]) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

endpackage

@@ rtl/stp_div.sv @@
// Radix-2 restoring unsigned divider, 64 by 64 bits, one quotient bit per cycle.
module stp_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic        busy,
   output logic [63:0] quo,
   output logic [63:0] rem
);
   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] q_ff, q_in;
   logic [63:0] r_ff, r_in;
   logic [63:0] d_ff, d_in;
   logic [64:0] shifted;
   logic [64:0] diff;

   always_comb begin
      shifted = {r_ff, q_ff[63]};
      diff    = shifted - {1'b0, d_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      if (go) begin
         busy_in = 1'b1;
         cnt_in  = 6'd63;
         q_in    = num;
         r_in    = '0;
         d_in    = den;
      end else if (busy_ff) begin
         if (!diff[64]) begin
            r_in = diff[63:0];
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = shifted[63:0];
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign busy = busy_ff;
   assign quo  = q_ff;
   assign rem  = r_ff;
endmodule

@@ rtl/stp_sqrt.sv @@
// Restoring integer square root of an 80-bit value, one root bit per cycle.
module stp_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [79:0] radicand,
   output logic        busy,
   output logic [39:0] root
);
   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [79:0] x_ff, x_in;
   logic [41:0] rem_ff, rem_in;
   logic [39:0] root_ff, root_in;
   logic [43:0] trial_rem;
   logic [43:0] trial;
   logic [43:0] diff;

   always_comb begin
      trial_rem = {rem_ff, x_ff[79:78]};
      trial     = {2'b00, root_ff, 2'b01};
      diff      = trial_rem - trial;
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      x_in      = x_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      if (go) begin
         busy_in = 1'b1;
         cnt_in  = 6'd39;
         x_in    = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         x_in = {x_ff[77:0], 2'b00};
         if (trial_rem >= trial) begin
            rem_in  = diff[41:0];
            root_in = {root_ff[38:0], 1'b1};
         end else begin
            rem_in  = trial_rem[41:0];
            root_in = {root_ff[38:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;
endmodule

@@ rtl/stp_dp.sv @@
// Datapath: config registers, move state, shared multiplier, divider and square root.
module stp_dp (
   input  logic                clock,
   input  logic                reset,
   input  stp_pkg::cmd_type    cmd,
   input  logic [23:0]         total_steps,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [29:0]         csr_data,
   output stp_pkg::status_type status,
   output stp_pkg::rsp_type    res
);
   import stp_pkg::*;

   logic [16:0] sa_ff;
   logic [29:0] clk_ff;
   logic [23:0] ar_ff, dr_ff, cs_ff;

   logic [1:0]  phase_ff, phase_in;
   logic [31:0] idx_ff, idx_in;
   logic [31:0] remr_ff, remr_in;
   logic [31:0] last_ff, last_in;
   logic [31:0] steps_ff, steps_in;
   logic [31:0] limit_ff, limit_in;
   logic [31:0] dstart_ff, dstart_in;
   logic [23:0] mlen_ff, mlen_in;
   logic        upd_ff, upd_in;

   logic [63:0] prod_ff, prod_in;
   logic [63:0] tmp_ff, tmp_in;
   logic [22:0] t1_ff, t1_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;

   logic        div_go, sqrt_go, div_busy, sqrt_busy;
   logic [63:0] div_num, div_den, quo, rem;
   logic [39:0] root;

   // period update operands
   logic [35:0] n_val, d_val, n_mag, d_mag;
   logic        n_neg, q_neg;
   logic [37:0] q_s, new_last;
   logic [35:0] r_s;
   logic [31:0] idx1, cthr, mag;

   // output shaping
   logic [32:0] neg_ds;
   logic [33:0] done_dec;

   assign mul_p = mul_a * mul_b;

   always_comb begin
      n_val = {3'b000, last_ff, 1'b0} + {{4{remr_ff[31]}}, remr_ff};
      d_val = {{2{idx_ff[31]}}, idx_ff, 2'b01};
      n_neg = n_val[35];
      q_neg = n_val[35] ^ d_val[35];
      n_mag = n_neg ? 36'(0 - n_val) : n_val;
      d_mag = d_val[35] ? 36'(0 - d_val) : d_val;
      q_s   = q_neg ? 38'(0 - {2'b00, quo[35:0]}) : {2'b00, quo[35:0]};
      r_s   = n_neg ? 36'(0 - rem[35:0]) : rem[35:0];
      new_last = {6'b0, last_ff} - q_s;
      idx1  = idx_ff + 32'd1;
      cthr  = {8'b0, mlen_ff} + dstart_ff;
      mag   = sat32(quo);
      if (mag[31]) begin
         mag = 32'h7FFF_FFFF;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      idx_in    = idx_ff;
      remr_in   = remr_ff;
      last_in   = last_ff;
      steps_in  = steps_ff;
      limit_in  = limit_ff;
      dstart_in = dstart_ff;
      mlen_in   = mlen_ff;
      upd_in    = upd_ff;
      prod_in   = prod_ff;
      tmp_in    = tmp_ff;
      t1_in     = t1_ff;
      mul_a     = '0;
      mul_b     = '0;
      div_go    = 1'b0;
      div_num   = prod_ff;
      div_den   = tmp_ff;
      sqrt_go   = 1'b0;
      case (cmd.op)
         OP_LOAD: begin
            phase_in = PH_ACCEL;
            idx_in   = '0;
            remr_in  = '0;
            last_in  = '0;
            mlen_in  = total_steps;
            mul_a    = {8'b0, ar_ff};
            mul_b    = K_DEN_SCALE;
            prod_in  = mul_p;
         end
         OP_MDEN: begin
            mul_a   = prod_ff[31:0];
            mul_b   = {15'b0, sa_ff};
            prod_in = mul_p;
         end
         OP_MCS: begin
            // 200 * accel * angle is already the full divisor
            tmp_in  = prod_ff;
            mul_a   = {8'b0, cs_ff};
            mul_b   = {8'b0, cs_ff};
            prod_in = mul_p;
         end
         OP_DIV: begin
            div_go = 1'b1;
         end
         OP_SSTEPS: begin
            steps_in = sat32(quo);
            mul_a    = {8'b0, dr_ff};
            mul_b    = {8'b0, mlen_ff};
            prod_in  = mul_p;
            tmp_in   = {39'b0, {1'b0, ar_ff} + {1'b0, dr_ff}};
         end
         OP_SLIM: begin
            limit_in = sat32(quo);
            mul_a    = steps_ff;
            mul_b    = {8'b0, ar_ff};
            prod_in  = mul_p;
            tmp_in   = {40'b0, dr_ff};
         end
         OP_SMAG: begin
            dstart_in = 32'(0 - mag);
         end
         OP_SDST: begin
            dstart_in = limit_ff - {8'b0, mlen_ff};
         end
         OP_MT1: begin
            mul_a   = {2'b0, clk_ff};
            mul_b   = K_T1_MUL;
            prod_in = mul_p;
            tmp_in  = K_T1_DIV;
         end
         OP_ST1: begin
            t1_in   = quo[22:0];
            mul_a   = {15'b0, sa_ff};
            mul_b   = K_A_LO;
            prod_in = mul_p;
         end
         OP_MA: begin
            mul_a   = prod_ff[31:0];
            mul_b   = K_A_HI;
            prod_in = mul_p;
            tmp_in  = {40'b0, ar_ff};
         end
         OP_SQ: begin
            sqrt_go = 1'b1;
         end
         OP_MRL: begin
            mul_a   = {9'b0, t1_ff};
            mul_b   = {12'b0, root[19:0]};
            prod_in = mul_p;
         end
         OP_MRH: begin
            tmp_in  = prod_ff;
            mul_a   = {9'b0, t1_ff};
            mul_b   = {12'b0, root[39:20]};
            prod_in = mul_p;
         end
         OP_MSUM: begin
            prod_in = {prod_ff[43:0], 20'b0} + tmp_ff;
            tmp_in  = K_PR_DIV;
         end
         OP_SPR: begin
            last_in = sat32(quo);
         end
         OP_NEXT: begin
            idx_in = idx1;
            upd_in = 1'b1;
            case (phase_ff)
               PH_ACCEL: begin
                  if (idx1 > limit_ff) begin
                     phase_in = PH_DECEL;
                     idx_in   = dstart_ff;
                  end else if (idx1 > steps_ff) begin
                     phase_in = PH_CONST;
                  end
               end
               PH_CONST: begin
                  if (idx1 > cthr) begin
                     phase_in = PH_DECEL;
                     idx_in   = dstart_ff;
                  end else begin
                     upd_in = 1'b0;
                  end
               end
               PH_DECEL: begin
                  if (idx1 == 32'd0) begin
                     phase_in = PH_STOP;
                     last_in  = '0;
                     remr_in  = '0;
                     upd_in   = 1'b0;
                  end
               end
               default: begin
                  phase_in = PH_ACCEL;
                  idx_in   = '0;
                  remr_in  = '0;
                  last_in  = '0;
               end
            endcase
         end
         OP_DUPD: begin
            div_go  = 1'b1;
            div_num = {28'b0, n_mag};
            div_den = {28'b0, d_mag};
         end
         OP_SUPD: begin
            remr_in = r_s[31:0];
            if (new_last[37]) begin
               last_in = '0;
            end else if (|new_last[36:32]) begin
               last_in = 32'hFFFF_FFFF;
            end else begin
               last_in = new_last[31:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_ff     <= RST_STEP_ANGLE;
         clk_ff    <= RST_TIMER_CLK;
         ar_ff     <= RST_ACCEL;
         dr_ff     <= RST_DECEL;
         cs_ff     <= RST_CRUISE;
         phase_ff  <= PH_ACCEL;
         idx_ff    <= '0;
         remr_ff   <= '0;
         last_ff   <= '0;
         steps_ff  <= '0;
         limit_ff  <= '0;
         dstart_ff <= '0;
         mlen_ff   <= '0;
         upd_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_STEP_ANGLE: sa_ff  <= csr_data[16:0];
               REG_TIMER_CLK:  clk_ff <= csr_data;
               REG_ACCEL:      ar_ff  <= csr_data[23:0];
               REG_DECEL:      dr_ff  <= csr_data[23:0];
               REG_CRUISE:     cs_ff  <= csr_data[23:0];
               default: begin
               end
            endcase
         end
         phase_ff  <= phase_in;
         idx_ff    <= idx_in;
         remr_ff   <= remr_in;
         last_ff   <= last_in;
         steps_ff  <= steps_in;
         limit_ff  <= limit_in;
         dstart_ff <= dstart_in;
         mlen_ff   <= mlen_in;
         upd_ff    <= upd_in;
      end
      prod_ff <= prod_in;
      tmp_ff  <= tmp_in;
      t1_ff   <= t1_in;
   end

   stp_div u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quo   (quo),
      .rem   (rem)
   );

   stp_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .go       (sqrt_go),
      .radicand ({quo, 16'b0}),
      .busy     (sqrt_busy),
      .root     (root)
   );

   always_comb begin
      status.div_busy  = div_busy;
      status.sqrt_busy = sqrt_busy;
      status.limit_gt  = limit_ff > steps_ff;
      status.upd_need  = upd_ff;

      neg_ds   = 33'(0) - {dstart_ff[31], dstart_ff};
      done_dec = {10'b0, mlen_ff} + {{2{idx_ff[31]}}, idx_ff} + 34'd1;

      res.counter_value   = (phase_ff == PH_STOP) ? 32'd0 : last_ff;
      res.phase           = phase_ff;
      res.accel_steps_out = (steps_ff < limit_ff) ? steps_ff : limit_ff;
      if (neg_ds[32]) begin
         res.decel_steps_out = '0;
      end else if (|neg_ds[31:24]) begin
         res.decel_steps_out = 24'hFF_FFFF;
      end else begin
         res.decel_steps_out = neg_ds[23:0];
      end
      if (phase_ff == PH_DECEL) begin
         if (done_dec[33]) begin
            res.steps_done = '0;
         end else if (|done_dec[32:24]) begin
            res.steps_done = 24'hFF_FFFF;
         end else begin
            res.steps_done = done_dec[23:0];
         end
      end else begin
         res.steps_done = (|idx_ff[31:24]) ? 24'hFF_FFFF : idx_ff[23:0];
      end
   end
endmodule

@@ rtl/stp_ctrl.sv @@
// Sequencer: walks the datapath through the start and next-step computations.
module stp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_opcode,
   input  logic                rsp_free,
   input  stp_pkg::status_type status,
   output logic                req_ready,
   output stp_pkg::cmd_type    cmd
);
   import stp_pkg::*;

   localparam logic [5:0] S_IDLE   = 6'd0;
   localparam logic [5:0] S_MDEN   = 6'd1;
   localparam logic [5:0] S_MCS    = 6'd2;
   localparam logic [5:0] S_DIVA   = 6'd3;
   localparam logic [5:0] S_WA     = 6'd4;
   localparam logic [5:0] S_SSTEPS = 6'd5;
   localparam logic [5:0] S_DIVB   = 6'd6;
   localparam logic [5:0] S_WB     = 6'd7;
   localparam logic [5:0] S_SLIM   = 6'd8;
   localparam logic [5:0] S_CHK    = 6'd9;
   localparam logic [5:0] S_DIVC   = 6'd10;
   localparam logic [5:0] S_WC     = 6'd11;
   localparam logic [5:0] S_SMAG   = 6'd12;
   localparam logic [5:0] S_SDST   = 6'd13;
   localparam logic [5:0] S_MT1    = 6'd14;
   localparam logic [5:0] S_DIVD   = 6'd15;
   localparam logic [5:0] S_WD     = 6'd16;
   localparam logic [5:0] S_ST1    = 6'd17;
   localparam logic [5:0] S_MA     = 6'd18;
   localparam logic [5:0] S_DIVE   = 6'd19;
   localparam logic [5:0] S_WE     = 6'd20;
   localparam logic [5:0] S_SQ     = 6'd21;
   localparam logic [5:0] S_WSQ    = 6'd22;
   localparam logic [5:0] S_MRL    = 6'd23;
   localparam logic [5:0] S_MRH    = 6'd24;
   localparam logic [5:0] S_MSUM   = 6'd25;
   localparam logic [5:0] S_DIVF   = 6'd26;
   localparam logic [5:0] S_WF     = 6'd27;
   localparam logic [5:0] S_SPR    = 6'd28;
   localparam logic [5:0] S_CHKU   = 6'd29;
   localparam logic [5:0] S_DUPD   = 6'd30;
   localparam logic [5:0] S_WU     = 6'd31;
   localparam logic [5:0] S_SUPD   = 6'd32;
   localparam logic [5:0] S_RESP   = 6'd33;

   logic [5:0] state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      cmd.rsp_load = 1'b0;
      req_ready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_opcode == OPC_NEXT) begin
                  cmd.op   = OP_NEXT;
                  state_in = S_CHKU;
               end else begin
                  cmd.op   = OP_LOAD;
                  state_in = S_MDEN;
               end
            end
         end
         S_MDEN:   begin cmd.op = OP_MDEN;   state_in = S_MCS;    end
         S_MCS:    begin cmd.op = OP_MCS;    state_in = S_DIVA;   end
         S_DIVA:   begin cmd.op = OP_DIV;    state_in = S_WA;     end
         S_WA:     if (!status.div_busy) state_in = S_SSTEPS;
         S_SSTEPS: begin cmd.op = OP_SSTEPS; state_in = S_DIVB;   end
         S_DIVB:   begin cmd.op = OP_DIV;    state_in = S_WB;     end
         S_WB:     if (!status.div_busy) state_in = S_SLIM;
         S_SLIM:   begin cmd.op = OP_SLIM;   state_in = S_CHK;    end
         S_CHK:    state_in = status.limit_gt ? S_DIVC : S_SDST;
         S_DIVC:   begin cmd.op = OP_DIV;    state_in = S_WC;     end
         S_WC:     if (!status.div_busy) state_in = S_SMAG;
         S_SMAG:   begin cmd.op = OP_SMAG;   state_in = S_MT1;    end
         S_SDST:   begin cmd.op = OP_SDST;   state_in = S_MT1;    end
         S_MT1:    begin cmd.op = OP_MT1;    state_in = S_DIVD;   end
         S_DIVD:   begin cmd.op = OP_DIV;    state_in = S_WD;     end
         S_WD:     if (!status.div_busy) state_in = S_ST1;
         S_ST1:    begin cmd.op = OP_ST1;    state_in = S_MA;     end
         S_MA:     begin cmd.op = OP_MA;     state_in = S_DIVE;   end
         S_DIVE:   begin cmd.op = OP_DIV;    state_in = S_WE;     end
         S_WE:     if (!status.div_busy) state_in = S_SQ;
         S_SQ:     begin cmd.op = OP_SQ;     state_in = S_WSQ;    end
         S_WSQ:    if (!status.sqrt_busy) state_in = S_MRL;
         S_MRL:    begin cmd.op = OP_MRL;    state_in = S_MRH;    end
         S_MRH:    begin cmd.op = OP_MRH;    state_in = S_MSUM;   end
         S_MSUM:   begin cmd.op = OP_MSUM;   state_in = S_DIVF;   end
         S_DIVF:   begin cmd.op = OP_DIV;    state_in = S_WF;     end
         S_WF:     if (!status.div_busy) state_in = S_SPR;
         S_SPR:    begin cmd.op = OP_SPR;    state_in = S_RESP;   end
         S_CHKU:   state_in = status.upd_need ? S_DUPD : S_RESP;
         S_DUPD:   begin cmd.op = OP_DUPD;   state_in = S_WU;     end
         S_WU:     if (!status.div_busy) state_in = S_SUPD;
         S_SUPD:   begin cmd.op = OP_SUPD;   state_in = S_RESP;   end
         S_RESP: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

@@ rtl/stepper_trapezoid_ramp_top.sv @@
// Top level of the trapezoid ramp stepper period generator.
//
//  channel   dir   handshake               payload
//  req_*     in    req_valid / req_ready   req_data  (opcode, total_steps)
//  rsp_*     out   rsp_valid / rsp_ready   rsp_data  (period, phase, step counts)
//  csr_*     in    csr_valid / csr_ready   csr_index, csr_data
//
// One request at a time. A start request runs the square root, the setup
// steps and six passes of the 64-bit radix-2 divider when the decel start
// comes from the accel steps, or five passes when it comes from the limit.
// A next request skips the divider when the period is held or stops, and
// runs the period recurrence, one divider pass, otherwise. A result
// stalled on rsp_ready keeps the next result waiting until it is taken.
// Reset (synchronous) restores register defaults and an empty move. The
// result sits in an output register, so a new request is taken while an
// earlier result still waits on rsp_ready.
module stepper_trapezoid_ramp_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  stp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output stp_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [29:0]      csr_data
);
   import stp_pkg::*;

   cmd_type    cmd;
   status_type status;
   rsp_type    res;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    rsp_free;

   // registers are written whenever asked; the port never stalls
   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   stp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .rsp_free   (rsp_free),
      .status     (status),
      .req_ready  (req_ready),
      .cmd        (cmd)
   );

   stp_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .total_steps (req_data.total_steps),
      .csr_we      (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .status      (status),
      .res         (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

@@ rtl/stp_chk.sv @@
// Port-level checks for the trapezoid ramp top, bound to every instance.
module stp_chk (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input stp_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input stp_pkg::rsp_type rsp_data,
   input logic             csr_valid,
   input logic             csr_ready,
   input logic [2:0]       csr_index,
   input logic [29:0]      csr_data
);
   import stp_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // one request in flight: busy right after a request is taken
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // stopped motor has no period
   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.phase == PH_STOP |-> rsp_data.counter_value == 32'd0)
      else $error("nonzero period in stop");

   // reset empties the output
   a_rst_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind stepper_trapezoid_ramp_top stp_chk u_stp_chk (.*);
